// ===== rtl/trtn_pkg.sv =====
`timescale 1ns / 1ps
package trtn_pkg;

   // Coordinate and normal formats.
   localparam int COORD_BITS       = 24;
   localparam int NORMAL_FRAC_BITS = 15;

   // Derived widths.
   localparam int DW   = COORD_BITS + 1;        // edge vector component
   localparam int PW   = 2 * DW;                // one cross product term
   localparam int CW   = PW + 1;                // cross product component, signed
   localparam int MW   = PW;                    // cross product magnitude
   localparam int LW   = MW / 2;                // low half for squaring
   localparam int HW   = MW - LW;               // high half for squaring
   localparam int SW   = 2 * MW + 2;            // sum of squares
   localparam int RW   = SW / 2;                // square root
   localparam int QB   = NORMAL_FRAC_BITS + 1;  // quotient bits per normal lane
   localparam int NW   = NORMAL_FRAC_BITS + 1;  // normal field width
   localparam int AW   = 2 * COORD_BITS + 1;    // area field width
   localparam int UW   = COORD_BITS + 3;        // biased vertex sum
   localparam int CS   = UW + 2;                // reciprocal shift for divide by 3
   localparam int UPW  = UW + CS;

   localparam logic [CS-1:0] RECIP3 = CS'((longint'(1) << CS) / 3 + 1);
   localparam logic [UW-1:0] SUM_BIAS = UW'(3 * (longint'(1) << COORD_BITS) + 1);
   localparam logic [NW-1:0] NORMAL_MAX = NW'((longint'(1) << NORMAL_FRAC_BITS) - 1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex0_x;
      logic signed [COORD_BITS-1:0] vertex0_y;
      logic signed [COORD_BITS-1:0] vertex0_z;
      logic signed [COORD_BITS-1:0] vertex1_x;
      logic signed [COORD_BITS-1:0] vertex1_y;
      logic signed [COORD_BITS-1:0] vertex1_z;
      logic signed [COORD_BITS-1:0] vertex2_x;
      logic signed [COORD_BITS-1:0] vertex2_y;
      logic signed [COORD_BITS-1:0] vertex2_z;
   } req_type;

   typedef struct packed {
      logic        [AW-1:0]         area;
      logic signed [NW-1:0]         normal_x;
      logic signed [NW-1:0]         normal_y;
      logic signed [NW-1:0]         normal_z;
      logic signed [COORD_BITS-1:0] centroid_x;
      logic signed [COORD_BITS-1:0] centroid_y;
      logic signed [COORD_BITS-1:0] centroid_z;
      logic                         degenerate;
   } rsp_type;

   // Data that rides along the square root chain.
   typedef struct packed {
      logic [2:0]                 neg;
      logic [2:0][MW-1:0]         mag;
      logic [2:0][COORD_BITS-1:0] cen;
   } side_type;

   // One square root cell's register set.
   typedef struct packed {
      logic          valid;
      logic [SW-1:0] s;
      logic [RW-1:0] root;
      logic [RW:0]   rem;
      side_type      side;
   } sq_type;

   // One divider cell's register set, three lanes for x, y and z.
   typedef struct packed {
      logic                       valid;
      logic [RW-1:0]              root;
      logic [QB-1:0]              nlo;
      logic [2:0][RW:0]           rem;
      logic [2:0][QB-1:0]         q;
      logic [2:0]                 neg;
      logic [2:0][COORD_BITS-1:0] cen;
   } dv_type;

endpackage

// ===== rtl/trtn_front.sv =====
`timescale 1ns / 1ps
module trtn_front import trtn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  req_type in_data,
   output sq_type  out
);

   logic signed [DW-1:0] a_ff [3];
   logic signed [DW-1:0] b_ff [3];
   logic [UW-1:0]        u_ff [3];
   logic                 v1_ff;

   logic signed [PW-1:0] p_ff [3];
   logic signed [PW-1:0] m_ff [3];
   logic [UPW-1:0]       cp_ff [3];
   logic                 v2_ff;

   side_type             sd3_ff;
   logic                 v3_ff;

   logic [2*HW-1:0]      hh_ff [3];
   logic [HW+LW-1:0]     hl_ff [3];
   logic [2*LW-1:0]      ll_ff [3];
   side_type             sd4_ff;
   logic                 v4_ff;

   logic [SW-1:0]        s_ff;
   side_type             sd5_ff;
   logic                 v5_ff;

   logic signed [COORD_BITS-1:0] v0 [3];
   logic signed [COORD_BITS-1:0] v1 [3];
   logic signed [COORD_BITS-1:0] v2 [3];
   logic signed [CW-1:0]         c   [3];
   logic [SW-1:0]                s_in;

   always_comb begin
      v0[0] = in_data.vertex0_x; v0[1] = in_data.vertex0_y; v0[2] = in_data.vertex0_z;
      v1[0] = in_data.vertex1_x; v1[1] = in_data.vertex1_y; v1[2] = in_data.vertex1_z;
      v2[0] = in_data.vertex2_x; v2[1] = in_data.vertex2_y; v2[2] = in_data.vertex2_z;
      for (int k = 0; k < 3; k++) begin
         c[k] = CW'(p_ff[k]) - CW'(m_ff[k]);
      end
      s_in = '0;
      for (int k = 0; k < 3; k++) begin
         s_in = s_in + (SW'(hh_ff[k]) << (2 * LW)) + (SW'(hl_ff[k]) << (LW + 1))
              + SW'(ll_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Edge vectors and the biased vertex sum.
         for (int k = 0; k < 3; k++) begin
            a_ff[k] <= DW'(v1[k]) - DW'(v0[k]);
            b_ff[k] <= DW'(v2[k]) - DW'(v0[k]);
            u_ff[k] <= UW'(v0[k]) + UW'(v1[k]) + UW'(v2[k]) + SUM_BIAS;
         end
         // Cross product terms and the divide by three.
         p_ff[0] <= a_ff[1] * b_ff[2];
         m_ff[0] <= a_ff[2] * b_ff[1];
         p_ff[1] <= a_ff[2] * b_ff[0];
         m_ff[1] <= a_ff[0] * b_ff[2];
         p_ff[2] <= a_ff[0] * b_ff[1];
         m_ff[2] <= a_ff[1] * b_ff[0];
         for (int k = 0; k < 3; k++) begin
            cp_ff[k] <= UPW'(u_ff[k]) * UPW'(RECIP3);
         end
         // Sign and magnitude of the cross product.
         for (int k = 0; k < 3; k++) begin
            sd3_ff.neg[k] <= c[k][CW-1];
            sd3_ff.mag[k] <= c[k][CW-1] ? MW'(-c[k]) : MW'(c[k]);
            sd3_ff.cen[k] <= cp_ff[k][CS +: COORD_BITS];
         end
         // Squares in half-width partial products.
         for (int k = 0; k < 3; k++) begin
            hh_ff[k] <= (2*HW)'(sd3_ff.mag[k][MW-1:LW]) * (2*HW)'(sd3_ff.mag[k][MW-1:LW]);
            hl_ff[k] <= (HW+LW)'(sd3_ff.mag[k][MW-1:LW]) * (HW+LW)'(sd3_ff.mag[k][LW-1:0]);
            ll_ff[k] <= (2*LW)'(sd3_ff.mag[k][LW-1:0]) * (2*LW)'(sd3_ff.mag[k][LW-1:0]);
         end
         sd4_ff <= sd3_ff;
         s_ff   <= s_in;
         sd5_ff <= sd4_ff;
      end
   end

   always_comb begin
      out.valid = v5_ff;
      out.s     = s_ff;
      out.root  = '0;
      out.rem   = '0;
      out.side  = sd5_ff;
   end

endmodule

// ===== rtl/trtn_sqrt_cell.sv =====
`timescale 1ns / 1ps
module trtn_sqrt_cell import trtn_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  sq_type in_cell,
   output sq_type out_cell
);

   sq_type        cell_ff;
   logic [RW+2:0] t;
   logic [RW+2:0] trial;
   logic          take;

   // One root bit per cell: bring in two radicand bits, try 4*root+1.
   always_comb begin
      t     = {in_cell.rem[RW:0], in_cell.s[SW-1:SW-2]};
      trial = (RW+3)'({in_cell.root, 2'b01});
      take  = (t >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff.valid <= in_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff.s    <= in_cell.s << 2;
         cell_ff.root <= {in_cell.root[RW-2:0], take};
         cell_ff.rem  <= take ? (RW+1)'(t - trial) : (RW+1)'(t);
         cell_ff.side <= in_cell.side;
      end
   end

   assign out_cell = cell_ff;

endmodule

// ===== rtl/trtn_div_cell.sv =====
`timescale 1ns / 1ps
module trtn_div_cell import trtn_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  dv_type in_cell,
   output dv_type out_cell
);

   dv_type        cell_ff;
   logic [RW+1:0] t   [3];
   logic [RW+1:0] den;
   logic [2:0]    take;

   // One quotient bit per lane per cell, divisor is twice the root.
   always_comb begin
      den = (RW+2)'({in_cell.root, 1'b0});
      for (int k = 0; k < 3; k++) begin
         t[k]    = {in_cell.rem[k], in_cell.nlo[QB-1]};
         take[k] = (t[k] >= den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff.valid <= in_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff.root <= in_cell.root;
         cell_ff.nlo  <= in_cell.nlo << 1;
         for (int k = 0; k < 3; k++) begin
            cell_ff.rem[k] <= take[k] ? (RW+1)'(t[k] - den) : (RW+1)'(t[k]);
            cell_ff.q[k]   <= {in_cell.q[k][QB-2:0], take[k]};
         end
         cell_ff.neg <= in_cell.neg;
         cell_ff.cen <= in_cell.cen;
      end
   end

   assign out_cell = cell_ff;

endmodule

// ===== rtl/triangle_area_normal_centroid.sv =====
`timescale 1ns / 1ps
// Triangle area, unit normal and centroid. One triangle (three Q12.12 vertices) is taken
// per transaction and one result transaction comes back for each, in order. The block is
// a single pipeline that accepts a new transaction every cycle while it is not held; it has
// 5 front stages (edge vectors, cross product, magnitude, squares, sum of squares), one cell
// per root bit of the square root chain (51 cells), one cell per quotient bit of the normal
// divider chain (16 cells), and the output register. The whole pipeline holds while a
// result sits in the output register with rsp_stall high, so throughput is one transaction
// per cycle whenever the consumer keeps up. A zero-area triangle sets degenerate and
// returns a zero normal and zero area; the centroid is always valid.
module triangle_area_normal_centroid import trtn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // The pipeline moves as one whenever the output register is free or being drained.
   logic    en;
   sq_type  sq [RW+1];
   dv_type  dv [QB+1];
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   trtn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out      (sq[0])
   );

   // Square root chain, one result bit per cell.
   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      trtn_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_cell  (sq[i]),
         .out_cell (sq[i+1])
      );
   end

   // The divider starts from the magnitude scaled up by one bit more than the normal's fraction
   // bits, plus the root; with twice the root as divisor the quotient comes out rounded to nearest.
   always_comb begin
      dv[0].valid = sq[RW].valid;
      dv[0].root  = sq[RW].root;
      dv[0].nlo   = sq[RW].root[QB-1:0];
      dv[0].q     = '0;
      dv[0].neg   = sq[RW].side.neg;
      dv[0].cen   = sq[RW].side.cen;
      for (int k = 0; k < 3; k++) begin
         dv[0].rem[k] = (RW+1)'(sq[RW].side.mag[k]) + (RW+1)'(sq[RW].root >> QB);
      end
   end

   for (genvar i = 0; i < QB; i++) begin : g_div
      trtn_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_cell  (dv[i]),
         .out_cell (dv[i+1])
      );
   end

   // Final formatting: sign, saturation just below +1.0, zero normal when degenerate, rounded half area.
   logic [NW-1:0] nrm [3];
   logic          deg;
   logic [RW:0]   half;

   always_comb begin
      deg  = (dv[QB].root == '0);
      half = ((RW+1)'(dv[QB].root) + (RW+1)'(1)) >> 1;
      for (int k = 0; k < 3; k++) begin
         if (deg) begin
            nrm[k] = '0;
         end else if (dv[QB].neg[k]) begin
            nrm[k] = NW'(-dv[QB].q[k]);
         end else if (dv[QB].q[k] > QB'(NORMAL_MAX)) begin
            nrm[k] = NORMAL_MAX;
         end else begin
            nrm[k] = NW'(dv[QB].q[k]);
         end
      end
      rsp_in.area       = half[AW-1:0];
      rsp_in.normal_x   = nrm[0];
      rsp_in.normal_y   = nrm[1];
      rsp_in.normal_z   = nrm[2];
      rsp_in.centroid_x = dv[QB].cen[0];
      rsp_in.centroid_y = dv[QB].cen[1];
      rsp_in.centroid_z = dv[QB].cen[2];
      rsp_in.degenerate = deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv[QB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/trtn_checker.sv =====
`timescale 1ns / 1ps
module trtn_checker import trtn_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A held result stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A blocked output backs up into the input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   // Degenerate triangles give zero area and a zero normal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.area == '0 &&
      rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("degenerate result not zeroed");

   // Any other triangle has a nonzero area.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |-> rsp_data.area != '0)
      else $error("zero area on a proper triangle");

   // Reset empties the output.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind triangle_area_normal_centroid trtn_checker u_trtn_checker (.*);
